/* hdl/shash_pkg.sv */
`default_nettype none
package shash_pkg;

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_COMP  = 5'b00010,
    ST_FINAL = 5'b00100,
    ST_PAD   = 5'b01000,
    ST_OUT   = 5'b10000
  } state_t;

  typedef enum logic [2:0] {
    PH_NONE = 3'd0,
    PH_80   = 3'd1,
    PH_ZERO = 3'd2,
    PH_LEN  = 3'd3,
    PH_DONE = 3'd4
  } pad_phase_t;

  localparam logic [7:0] PAD_BYTE  = 8'h80;
  localparam logic [5:0] LEN_START = 6'd56;

  function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
    rotr = (x >> n) | (x << (32 - n));
  endfunction

  function automatic logic [31:0] big_sig0(input logic [31:0] x);
    big_sig0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
  endfunction

  function automatic logic [31:0] big_sig1(input logic [31:0] x);
    big_sig1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
  endfunction

  function automatic logic [31:0] small_sig0(input logic [31:0] x);
    small_sig0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
  endfunction

  function automatic logic [31:0] small_sig1(input logic [31:0] x);
    small_sig1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
  endfunction

  function automatic logic [31:0] init_hash(input logic [2:0] i);
    unique case (i)
      3'd0: init_hash = 32'h6a09e667;
      3'd1: init_hash = 32'hbb67ae85;
      3'd2: init_hash = 32'h3c6ef372;
      3'd3: init_hash = 32'ha54ff53a;
      3'd4: init_hash = 32'h510e527f;
      3'd5: init_hash = 32'h9b05688c;
      3'd6: init_hash = 32'h1f83d9ab;
      default: init_hash = 32'h5be0cd19;
    endcase
  endfunction

  function automatic logic [31:0] round_const(input logic [5:0] t);
    unique case (t)
      6'd0:  round_const = 32'h428a2f98;
      6'd1:  round_const = 32'h71374491;
      6'd2:  round_const = 32'hb5c0fbcf;
      6'd3:  round_const = 32'he9b5dba5;
      6'd4:  round_const = 32'h3956c25b;
      6'd5:  round_const = 32'h59f111f1;
      6'd6:  round_const = 32'h923f82a4;
      6'd7:  round_const = 32'hab1c5ed5;
      6'd8:  round_const = 32'hd807aa98;
      6'd9:  round_const = 32'h12835b01;
      6'd10: round_const = 32'h243185be;
      6'd11: round_const = 32'h550c7dc3;
      6'd12: round_const = 32'h72be5d74;
      6'd13: round_const = 32'h80deb1fe;
      6'd14: round_const = 32'h9bdc06a7;
      6'd15: round_const = 32'hc19bf174;
      6'd16: round_const = 32'he49b69c1;
      6'd17: round_const = 32'hefbe4786;
      6'd18: round_const = 32'h0fc19dc6;
      6'd19: round_const = 32'h240ca1cc;
      6'd20: round_const = 32'h2de92c6f;
      6'd21: round_const = 32'h4a7484aa;
      6'd22: round_const = 32'h5cb0a9dc;
      6'd23: round_const = 32'h76f988da;
      6'd24: round_const = 32'h983e5152;
      6'd25: round_const = 32'ha831c66d;
      6'd26: round_const = 32'hb00327c8;
      6'd27: round_const = 32'hbf597fc7;
      6'd28: round_const = 32'hc6e00bf3;
      6'd29: round_const = 32'hd5a79147;
      6'd30: round_const = 32'h06ca6351;
      6'd31: round_const = 32'h14292967;
      6'd32: round_const = 32'h27b70a85;
      6'd33: round_const = 32'h2e1b2138;
      6'd34: round_const = 32'h4d2c6dfc;
      6'd35: round_const = 32'h53380d13;
      6'd36: round_const = 32'h650a7354;
      6'd37: round_const = 32'h766a0abb;
      6'd38: round_const = 32'h81c2c92e;
      6'd39: round_const = 32'h92722c85;
      6'd40: round_const = 32'ha2bfe8a1;
      6'd41: round_const = 32'ha81a664b;
      6'd42: round_const = 32'hc24b8b70;
      6'd43: round_const = 32'hc76c51a3;
      6'd44: round_const = 32'hd192e819;
      6'd45: round_const = 32'hd6990624;
      6'd46: round_const = 32'hf40e3585;
      6'd47: round_const = 32'h106aa070;
      6'd48: round_const = 32'h19a4c116;
      6'd49: round_const = 32'h1e376c08;
      6'd50: round_const = 32'h2748774c;
      6'd51: round_const = 32'h34b0bcb5;
      6'd52: round_const = 32'h391c0cb3;
      6'd53: round_const = 32'h4ed8aa4a;
      6'd54: round_const = 32'h5b9cca4f;
      6'd55: round_const = 32'h682e6ff3;
      6'd56: round_const = 32'h748f82ee;
      6'd57: round_const = 32'h78a5636f;
      6'd58: round_const = 32'h84c87814;
      6'd59: round_const = 32'h8cc70208;
      6'd60: round_const = 32'h90befffa;
      6'd61: round_const = 32'ha4506ceb;
      6'd62: round_const = 32'hbef9a3f7;
      default: round_const = 32'hc67178f2;
    endcase
  endfunction

endpackage
`default_nettype wire

/* hdl/sha256_byte_stream_hasher_unit.sv */
`default_nettype none
// SHA-256 hasher fed one message byte per request. A request with
// in_end_of_message set closes the message (its byte is hashed first when
// in_byte_present is set); the block then pads, finishes the hash and returns
// the digest as eight requests of 32 bits, word 0 first, before it takes the
// next message. Every 64th byte starts the compression, which runs one round
// per cycle on a single round unit: 64 rounds, then a fold of the result into
// the hash words, with in_ready low throughout. Closing a message pushes the
// padding one byte per cycle through the same buffer port, held while a full
// block is compressed, with an idle step between the zero bytes and the length
// bytes, then runs the closing compression, plus one extra compression when
// the pad spills past byte 55; then the eight digest words leave at one per
// cycle as out_ready allows.
module sha256_byte_stream_hasher_unit (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  in_data_byte,
  input  wire logic        in_byte_present,
  input  wire logic        in_end_of_message,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [31:0]      out_digest_word,
  output logic [2:0]       out_word_index,
  output logic             out_last_word
);
  import shash_pkg::*;

  state_t      state_r, state_nxt;
  pad_phase_t  phase_r, phase_nxt;
  logic [5:0]  fill_r, fill_nxt;
  logic [60:0] len_r, len_nxt;
  logic [5:0]  rnd_r, rnd_nxt;
  logic [2:0]  idx_r, idx_nxt;
  logic [31:0] hash_r [8];
  logic [31:0] hash_nxt [8];
  logic [31:0] wv_r [8];
  logic [31:0] wv_nxt [8];
  // block buffer and message schedule window share these words
  logic [31:0] win_r [16];
  logic [31:0] win_nxt [16];

  logic        in_acc, out_acc;
  logic        push_en;
  logic [7:0]  push_byte;
  logic        wrap;
  logic [63:0] bit_len;
  logic [31:0] t1, t2, w_new;

  assign in_acc  = in_valid && in_ready;
  assign out_acc = out_valid && out_ready;
  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = (state_r == ST_OUT);
  assign out_digest_word = hash_r[idx_r];
  assign out_word_index  = idx_r;
  assign out_last_word   = (idx_r == 3'd7);
  assign bit_len = {len_r, 3'b000};
  assign wrap = push_en && (fill_r == 6'd63);

  // round unit
  always_comb begin
    t1 = wv_r[7] + big_sig1(wv_r[4]) + ((wv_r[4] & wv_r[5]) ^ (~wv_r[4] & wv_r[6]))
         + round_const(rnd_r) + win_r[0];
    t2 = big_sig0(wv_r[0])
         + ((wv_r[0] & wv_r[1]) ^ (wv_r[0] & wv_r[2]) ^ (wv_r[1] & wv_r[2]));
    w_new = small_sig1(win_r[14]) + win_r[9] + small_sig0(win_r[1]) + win_r[0];
  end

  always_comb begin
    state_nxt = state_r;
    phase_nxt = phase_r;
    fill_nxt  = fill_r;
    len_nxt   = len_r;
    rnd_nxt   = rnd_r;
    idx_nxt   = idx_r;
    push_en   = 1'b0;
    push_byte = in_data_byte;
    for (int i = 0; i < 8; i++) begin
      hash_nxt[i] = hash_r[i];
      wv_nxt[i]   = wv_r[i];
    end
    for (int i = 0; i < 16; i++) begin
      win_nxt[i] = win_r[i];
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          push_en = in_byte_present;
          if (in_byte_present) begin
            len_nxt = len_r + 61'd1;
          end
          if (in_end_of_message) begin
            phase_nxt = PH_80;
            state_nxt = ST_PAD;
          end
        end
      end
      ST_PAD: begin
        unique case (phase_r)
          PH_80: begin
            push_en   = 1'b1;
            push_byte = PAD_BYTE;
            phase_nxt = PH_ZERO;
          end
          PH_ZERO: begin
            if (fill_r == LEN_START) begin
              phase_nxt = PH_LEN;
            end else begin
              push_en   = 1'b1;
              push_byte = 8'h00;
            end
          end
          PH_LEN: begin
            push_en   = 1'b1;
            push_byte = bit_len[{~fill_r[2:0], 3'b000} +: 8];
            if (fill_r == 6'd63) begin
              phase_nxt = PH_DONE;
            end
          end
          default: begin
            phase_nxt = PH_DONE;
          end
        endcase
      end
      ST_COMP: begin
        for (int i = 0; i < 15; i++) begin
          win_nxt[i] = win_r[i + 1];
        end
        win_nxt[15] = w_new;
        wv_nxt[7] = wv_r[6];
        wv_nxt[6] = wv_r[5];
        wv_nxt[5] = wv_r[4];
        wv_nxt[4] = wv_r[3] + t1;
        wv_nxt[3] = wv_r[2];
        wv_nxt[2] = wv_r[1];
        wv_nxt[1] = wv_r[0];
        wv_nxt[0] = t1 + t2;
        rnd_nxt = rnd_r + 6'd1;
        if (rnd_r == 6'd63) begin
          state_nxt = ST_FINAL;
        end
      end
      ST_FINAL: begin
        for (int i = 0; i < 8; i++) begin
          hash_nxt[i] = hash_r[i] + wv_r[i];
        end
        priority if (phase_r == PH_DONE) begin
          state_nxt = ST_OUT;
        end else if (phase_r == PH_NONE) begin
          state_nxt = ST_IDLE;
        end else begin
          state_nxt = ST_PAD;
        end
      end
      ST_OUT: begin
        if (out_acc) begin
          idx_nxt = idx_r + 3'd1;
          if (idx_r == 3'd7) begin
            for (int i = 0; i < 8; i++) begin
              hash_nxt[i] = init_hash(3'(i));
            end
            len_nxt   = '0;
            phase_nxt = PH_NONE;
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    // byte write into the buffer, big-endian within each word
    if (push_en) begin
      win_nxt[fill_r[5:2]][{~fill_r[1:0], 3'b000} +: 8] = push_byte;
      fill_nxt = fill_r + 6'd1;
    end
    if (wrap) begin
      for (int i = 0; i < 8; i++) begin
        wv_nxt[i] = hash_r[i];
      end
      rnd_nxt   = '0;
      state_nxt = ST_COMP;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      phase_r <= PH_NONE;
      fill_r  <= '0;
      len_r   <= '0;
      rnd_r   <= '0;
      idx_r   <= '0;
      for (int i = 0; i < 8; i++) begin
        hash_r[i] <= init_hash(3'(i));
      end
    end else begin
      state_r <= state_nxt;
      phase_r <= phase_nxt;
      fill_r  <= fill_nxt;
      len_r   <= len_nxt;
      rnd_r   <= rnd_nxt;
      idx_r   <= idx_nxt;
      for (int i = 0; i < 8; i++) begin
        hash_r[i] <= hash_nxt[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 8; i++) begin
      wv_r[i] <= wv_nxt[i];
    end
    for (int i = 0; i < 16; i++) begin
      win_r[i] <= win_nxt[i];
    end
  end

  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid))
    else $error("input and output sides open together");

  a_back_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && out_last_word |=> in_ready)
    else $error("not idle after last digest word");

  a_round_end: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_COMP) && (rnd_r == 6'd63) |=> (state_r == ST_FINAL))
    else $error("compression did not finish after round 63");

  a_len_on_wrap: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_PAD) && (phase_r == PH_LEN) && (fill_r == 6'd63)
    |=> (state_r == ST_COMP) && (fill_r == 6'd0))
    else $error("length bytes did not close the block");

endmodule
`default_nettype wire

/* test/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;

  localparam int CYCLE_LIMIT = 400000;
  localparam int CALM_LO     = 1500;
  localparam int CALM_HI     = 3500;
  localparam int RANDOM_REQS = 300;
  localparam int TAIL_CYCLES = 200;
  localparam logic [7:0] PAD_MARK = 8'h80;
  localparam logic [5:0] LEN_SLOT = 6'd56;

  typedef struct {
    logic [7:0] data;
    logic       present;
    logic       eom;
    logic       drain;
  } byte_req_t;

  typedef struct {
    logic [31:0] word;
    logic [2:0]  idx;
    logic        last;
  } digest_word_t;

  logic clk;
  logic rst_n = 1'b0;

  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  in_data_byte = 8'h00;
  logic        in_byte_present = 1'b0;
  logic        in_end_of_message = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [31:0] out_digest_word;
  logic [2:0]  out_word_index;
  logic        out_last_word;

  sha256_byte_stream_hasher_unit dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_data_byte      (in_data_byte),
    .in_byte_present   (in_byte_present),
    .in_end_of_message (in_end_of_message),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_digest_word   (out_digest_word),
    .out_word_index    (out_word_index),
    .out_last_word     (out_last_word)
  );

  byte_req_t    send_q[$];
  digest_word_t digest_q[$];

  int cyc = 0;
  int err_cnt = 0;
  int msgs_done = 0;
  int bytes_hashed = 0;
  int empty_reqs = 0;
  int words_checked = 0;

  logic [31:0] rnd_k [0:63] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b,
    32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01,
    32'h243185be, 32'h550c7dc3, 32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7,
    32'hc19bf174, 32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da, 32'h983e5152,
    32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
    32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc,
    32'h53380d13, 32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3, 32'hd192e819,
    32'hd6990624, 32'hf40e3585, 32'h106aa070, 32'h19a4c116, 32'h1e376c08,
    32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f,
    32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  logic [31:0] hash_iv [0:7] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  // running hash of the message in flight
  logic [31:0] hash_state [0:7];
  logic [7:0]  blk_bytes [0:63];
  logic [5:0]  blk_fill = '0;
  logic [60:0] msg_bytes = '0;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cyc <= cyc + 1;
    if (cyc >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cyc);
      $display("Regression FAIL");
      $finish;
    end
  end

  function automatic logic [31:0] ror32(input logic [31:0] x, input int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  function automatic bit idle_roll();
    return (cyc < CALM_LO || cyc >= CALM_HI) && ($urandom_range(0, 99) < 21);
  endfunction

  task automatic restart_hash();
    for (int i = 0; i < 8; i++) hash_state[i] = hash_iv[i];
    blk_fill  = '0;
    msg_bytes = '0;
  endtask

  task automatic compress_block();
    logic [31:0] w [0:15];
    logic [31:0] v [0:7];
    logic [31:0] x15, x2, wt, t1, t2, s0, s1, ch, maj;
    for (int i = 0; i < 16; i++)
      w[i] = {blk_bytes[4*i], blk_bytes[4*i+1], blk_bytes[4*i+2], blk_bytes[4*i+3]};
    for (int i = 0; i < 8; i++) v[i] = hash_state[i];
    for (int t = 0; t < 64; t++) begin
      if (t < 16) begin
        wt = w[t];
      end else begin
        x15 = w[(t - 15) & 15];
        x2  = w[(t - 2) & 15];
        wt  = w[t & 15] + (ror32(x15, 7) ^ ror32(x15, 18) ^ (x15 >> 3))
            + w[(t - 7) & 15] + (ror32(x2, 17) ^ ror32(x2, 19) ^ (x2 >> 10));
        w[t & 15] = wt;
      end
      s1  = ror32(v[4], 6) ^ ror32(v[4], 11) ^ ror32(v[4], 25);
      ch  = (v[4] & v[5]) ^ (~v[4] & v[6]);
      s0  = ror32(v[0], 2) ^ ror32(v[0], 13) ^ ror32(v[0], 22);
      maj = (v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]);
      t1  = v[7] + s1 + ch + rnd_k[t] + wt;
      t2  = s0 + maj;
      v[7] = v[6];
      v[6] = v[5];
      v[5] = v[4];
      v[4] = v[3] + t1;
      v[3] = v[2];
      v[2] = v[1];
      v[1] = v[0];
      v[0] = t1 + t2;
    end
    for (int i = 0; i < 8; i++) hash_state[i] = hash_state[i] + v[i];
  endtask

  task automatic absorb_byte(input logic [7:0] b);
    blk_bytes[blk_fill] = b;
    blk_fill = blk_fill + 6'd1;
    if (blk_fill == 6'd0) compress_block();
  endtask

  // update the running hash with one accepted request, queue the digest on close
  task automatic hash_request(input byte_req_t r);
    logic [63:0]  bit_len;
    digest_word_t dw;
    if (r.present) begin
      msg_bytes = msg_bytes + 61'd1;
      absorb_byte(r.data);
      bytes_hashed++;
    end else if (!r.eom) begin
      empty_reqs++;
    end
    if (r.eom) begin
      bit_len = {msg_bytes, 3'b000};
      absorb_byte(PAD_MARK);
      while (blk_fill != LEN_SLOT) absorb_byte(8'h00);
      for (int i = 7; i >= 0; i--) absorb_byte(bit_len[8*i +: 8]);
      for (int i = 0; i < 8; i++) begin
        dw.word = hash_state[i];
        dw.idx  = i[2:0];
        dw.last = (i == 7);
        digest_q.push_back(dw);
      end
      msgs_done++;
      restart_hash();
    end
  endtask

  // driver
  always @(posedge clk) begin
    logic fire;
    logic may_send;
    fire = in_valid && in_ready;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (fire) begin
        hash_request(send_q[0]);
        send_q.pop_front();
      end
      if (!in_valid || fire) begin
        may_send = (send_q.size() > 0) && !idle_roll();
        // a drain request waits until every digest word is back
        if (may_send && send_q[0].drain && digest_q.size() != 0) may_send = 1'b0;
        if (may_send) begin
          in_valid          <= 1'b1;
          in_data_byte      <= send_q[0].data;
          in_byte_present   <= send_q[0].present;
          in_end_of_message <= send_q[0].eom;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  int  stall_left = 0;
  bit  stall_done = 1'b0;

  always @(posedge clk) begin
    digest_word_t exp_w;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        words_checked++;
        if (digest_q.size() == 0) begin
          $error("unexpected digest word %h index %0d last %0d",
                 out_digest_word, out_word_index, out_last_word);
          err_cnt++;
        end else begin
          exp_w = digest_q.pop_front();
          if (out_digest_word !== exp_w.word) begin
            $error("digest_word expected %h actual %h", exp_w.word, out_digest_word);
            err_cnt++;
          end
          if (out_word_index !== exp_w.idx) begin
            $error("word_index expected %0d actual %0d", exp_w.idx, out_word_index);
            err_cnt++;
          end
          if (out_last_word !== exp_w.last) begin
            $error("last_word expected %0d actual %0d", exp_w.last, out_last_word);
            err_cnt++;
          end
        end
      end
      // one long hold-off on the result side while the sender waits with its next request
      if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else if (!stall_done && out_valid && cyc > 600) begin
        stall_left = 300;
        stall_done = 1'b1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= !idle_roll();
      end
    end
  end

  task automatic push_req(input logic [7:0] d, input logic p, input logic e,
                          input logic dr, inout int cnt);
    byte_req_t r;
    r.data    = d;
    r.present = p;
    r.eom     = e;
    r.drain   = dr;
    send_q.push_back(r);
    if (p || e) cnt++;
  endtask

  // well-formed message with random content and the odd empty request mixed in
  task automatic queue_message(input int len, input bit close_with_byte,
                               input bit drain, inout int cnt);
    bit with_byte;
    bit dr;
    with_byte = close_with_byte && (len > 0);
    dr = drain;
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(0, 99) < 8) begin
        push_req(8'($urandom_range(0, 255)), 1'b0, 1'b0, dr, cnt);
        dr = 1'b0;
      end
      push_req(8'($urandom_range(0, 255)), 1'b1, with_byte && (i == len - 1), dr, cnt);
      dr = 1'b0;
    end
    if (!with_byte) push_req(8'($urandom_range(0, 255)), 1'b0, 1'b1, dr, cnt);
  endtask

  int boundary_len [0:8] = '{0, 1, 55, 56, 57, 63, 64, 65, 120};

  initial begin
    int dir_cnt;
    int rnd_cnt;
    int len;
    int pick;
    int msg_no;
    dir_cnt = 0;
    rnd_cnt = 0;
    msg_no  = 0;
    restart_hash();

    // empty message, then single-byte messages at both byte extremes
    push_req(8'hff, 1'b0, 1'b1, 1'b0, dir_cnt);
    push_req(8'h00, 1'b1, 1'b1, 1'b0, dir_cnt);
    push_req(8'hff, 1'b1, 1'b1, 1'b0, dir_cnt);
    // "abc" with an empty request inside, closed by a request without a byte
    push_req(8'h61, 1'b1, 1'b0, 1'b0, dir_cnt);
    push_req(8'h00, 1'b0, 1'b0, 1'b0, dir_cnt);
    push_req(8'h62, 1'b1, 1'b0, 1'b0, dir_cnt);
    push_req(8'h63, 1'b1, 1'b0, 1'b0, dir_cnt);
    push_req(8'hff, 1'b0, 1'b1, 1'b0, dir_cnt);
    // empty requests ahead of a message, then two empty messages back to back
    push_req(8'haa, 1'b0, 1'b0, 1'b1, dir_cnt);
    push_req(8'h55, 1'b0, 1'b0, 1'b0, dir_cnt);
    push_req(8'h55, 1'b1, 1'b0, 1'b0, dir_cnt);
    push_req(8'haa, 1'b1, 1'b1, 1'b0, dir_cnt);
    push_req(8'h00, 1'b0, 1'b1, 1'b0, dir_cnt);
    push_req(8'h00, 1'b0, 1'b1, 1'b0, dir_cnt);

    while (rnd_cnt < RANDOM_REQS) begin
      pick = $urandom_range(0, 99);
      if (pick < 55) len = $urandom_range(0, 12);
      else if (pick < 80) len = boundary_len[$urandom_range(0, 8)];
      else len = $urandom_range(13, 130);
      queue_message(len, 1'($urandom_range(0, 1)),
                    (msg_no == 6) || ($urandom_range(0, 99) < 5), rnd_cnt);
      msg_no++;
    end

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    while (send_q.size() != 0 || digest_q.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("hashed %0d messages, %0d bytes, %0d empty requests", msgs_done,
             bytes_hashed, empty_reqs);
    $display("checked %0d digest words in %0d cycles", words_checked, cyc);
    if (err_cnt == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

/* filelist.f */
hdl/shash_pkg.sv
hdl/sha256_byte_stream_hasher_unit.sv
test/tb_top.sv
